FILE: rtl/prc_pkg.sv
`default_nettype none

package prc_pkg;

    localparam int ATAN_ENTRIES = 24;

    localparam int COORD_W = 12;
    localparam int ROWS_W  = 13;
    localparam int ANGLE_W = 17;
    localparam int DIFF_W  = 13;
    localparam int OUT_W   = 15;

    localparam int XY_W = 19;
    localparam int Z_W  = 24;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q16 = 19'sd39797;

    localparam logic signed [17:0] HALF_TURN    = 18'sd46080;
    localparam logic signed [17:0] QUARTER_TURN = 18'sd23040;
    localparam logic signed [17:0] FULL_TURN    = 18'sd92160;

    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic [COORD_W-1:0]       cx;
        logic [COORD_W-1:0]       cy;
        logic                     neg;
    } geom_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        geom_t                  geom;
    } cordic_word_t;

    function automatic logic signed [Z_W-1:0] atan_q16(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 24'sd2949120;
            5'd1:    v = 24'sd1740967;
            5'd2:    v = 24'sd919879;
            5'd3:    v = 24'sd466945;
            5'd4:    v = 24'sd234379;
            5'd5:    v = 24'sd117304;
            5'd6:    v = 24'sd58666;
            5'd7:    v = 24'sd29335;
            5'd8:    v = 24'sd14668;
            5'd9:    v = 24'sd7334;
            5'd10:   v = 24'sd3667;
            5'd11:   v = 24'sd1833;
            5'd12:   v = 24'sd917;
            5'd13:   v = 24'sd458;
            5'd14:   v = 24'sd229;
            5'd15:   v = 24'sd115;
            5'd16:   v = 24'sd57;
            5'd17:   v = 24'sd29;
            5'd18:   v = 24'sd14;
            5'd19:   v = 24'sd7;
            5'd20:   v = 24'sd4;
            5'd21:   v = 24'sd2;
            5'd22:   v = 24'sd1;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/prc_if.sv
`default_nettype none

interface prc_point_if;
    logic               valid;
    logic               ready;
    logic [11:0]        point_x;
    logic [11:0]        point_y;
    logic [11:0]        center_x;
    logic [11:0]        center_y;
    logic signed [16:0] angle_deg;

    modport source (
        output valid, point_x, point_y, center_x, center_y, angle_deg,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, center_x, center_y, angle_deg,
        output ready
    );
endinterface

interface prc_result_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] rotated_x;
    logic signed [14:0] rotated_y;

    modport source (
        output valid, rotated_x, rotated_y,
        input  ready
    );
    modport sink (
        input  valid, rotated_x, rotated_y,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/prc_cordic.sv
`default_nettype none

module prc_cordic
    import prc_pkg::*;
#(
    parameter int STAGES = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire cordic_word_t in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output cordic_word_t      out_data
);

    cordic_word_t             word_reg [STAGES];
    logic [STAGES-1:0]        valid_reg;
    logic [STAGES:0]          rdy;

    assign rdy[STAGES] = out_ready;
    assign in_ready    = rdy[0];
    assign out_valid   = valid_reg[STAGES-1];
    assign out_data    = word_reg[STAGES-1];

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        cordic_word_t           word_in;
        cordic_word_t           word_next;
        logic                   valid_in;
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;

        if (i == 0)
        begin : g_first
            assign word_in  = in_data;
            assign valid_in = in_valid;
        end
        else
        begin : g_rest
            assign word_in  = word_reg[i-1];
            assign valid_in = valid_reg[i-1];
        end

        assign rdy[i] = !valid_reg[i] || rdy[i+1];
        assign xs     = word_in.x >>> i;
        assign ys     = word_in.y >>> i;

        always_comb
        begin
            word_next = word_in;
            if (!word_in.z[Z_W-1])
            begin
                word_next.x = word_in.x - ys;
                word_next.y = word_in.y + xs;
                word_next.z = word_in.z - atan_q16(5'(i));
            end
            else
            begin
                word_next.x = word_in.x + ys;
                word_next.y = word_in.y - xs;
                word_next.z = word_in.z + atan_q16(5'(i));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (rdy[i+1] || !valid_reg[i])
            begin
                valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (valid_in && rdy[i])
            begin
                word_reg[i] <= word_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/point_rotate_about_center.sv
`default_nettype none

// Channel   Dir  Handshake      Word
// points    in   valid/ready    point_x, point_y, center_x, center_y, angle_deg
// results   out  valid/ready    rotated_x, rotated_y
// cfg       in   cfg_we         cfg_data (image_rows)
//
// One word enters every cycle unless the output stalls; the path holds one
// register per CORDIC micro-rotation plus wrap, fold, sign, multiply, sum,
// round and output stages. Each stage holds its own valid bit and fills bubbles,
// so a stalled output holds words in place and drops none. rst_n clears all
// valid bits and sets image_rows to 1024.

module point_rotate_about_center
    import prc_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    prc_point_if.sink              points,
    prc_result_if.source           results,
    input  wire logic              cfg_we,
    input  wire logic [ROWS_W-1:0] cfg_data
);

    localparam int STAGES = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int P_W    = 32;
    localparam int SUM_W  = 33;
    localparam int Q_W    = SUM_W - 16;
    localparam int R_W    = 18;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        geom_t                     geom;
    } wrap_word_t;

    typedef struct packed {
        logic signed [XY_W-1:0]   c;
        logic signed [XY_W-1:0]   s;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic [COORD_W-1:0]       cx;
        logic signed [13:0]       y2;
    } sign_word_t;

    typedef struct packed {
        logic signed [P_W-1:0] dxc;
        logic signed [P_W-1:0] dys;
        logic signed [P_W-1:0] dxs;
        logic signed [P_W-1:0] dyc;
        logic [COORD_W-1:0]    cx;
        logic signed [13:0]    y2;
    } mul_word_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
    } sum_word_t;

    typedef struct packed {
        logic signed [Q_W-1:0] qx;
        logic signed [Q_W-1:0] qy;
    } rnd_word_t;

    function automatic logic signed [Q_W-1:0] round_even(input logic signed [SUM_W-1:0] v);
        logic signed [Q_W-1:0] q;
        logic                  up;
        q  = v[SUM_W-1:16];
        up = v[15] && ((v[14:0] != 15'd0) || q[0]);
        return q + Q_W'(up);
    endfunction

    function automatic logic signed [OUT_W-1:0] saturate(input logic signed [R_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v < -R_W'(16384))
        begin
            r = -15'sd16384;
        end
        else if (v > R_W'(16383))
        begin
            r = 15'sd16383;
        end
        else
        begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

    logic [ROWS_W-1:0] rows_reg;

    wrap_word_t   w_reg, w_next;
    cordic_word_t f_reg, f_next;
    sign_word_t   g_reg, g_next;
    mul_word_t    m_reg, m_next;
    sum_word_t    s_reg, s_next;
    rnd_word_t    r_reg, r_next;
    logic signed [OUT_W-1:0] ox_reg, ox_next, oy_reg, oy_next;

    logic w_valid_reg, f_valid_reg, g_valid_reg, m_valid_reg;
    logic s_valid_reg, r_valid_reg, o_valid_reg;
    logic w_rdy, f_rdy, g_rdy, m_rdy, s_rdy, r_rdy, o_rdy;

    logic         c_in_ready;
    logic         c_out_valid;
    cordic_word_t c_out_data;

    // ready chain: a stage advances when empty or when the next one takes its word
    assign o_rdy = !o_valid_reg || results.ready;
    assign r_rdy = !r_valid_reg || o_rdy;
    assign s_rdy = !s_valid_reg || r_rdy;
    assign m_rdy = !m_valid_reg || s_rdy;
    assign g_rdy = !g_valid_reg || m_rdy;
    assign f_rdy = !f_valid_reg || c_in_ready;
    assign w_rdy = !w_valid_reg || f_rdy;

    assign points.ready      = w_rdy;
    assign results.valid     = o_valid_reg;
    assign results.rotated_x = ox_reg;
    assign results.rotated_y = oy_reg;

    // wrap angle into [-180, 180) degrees, form point offsets
    always_comb
    begin
        logic signed [17:0] a;
        a = 18'(points.angle_deg);
        if (a < -HALF_TURN)
        begin
            a = a + FULL_TURN;
        end
        else if (a >= HALF_TURN)
        begin
            a = a - FULL_TURN;
        end
        w_next.angle    = a[ANGLE_W-1:0];
        w_next.geom.dx  = $signed({1'b0, points.point_x}) - $signed({1'b0, points.center_x});
        w_next.geom.dy  = $signed({1'b0, points.center_y}) - $signed({1'b0, points.point_y});
        w_next.geom.cx  = points.center_x;
        w_next.geom.cy  = points.center_y;
        w_next.geom.neg = 1'b0;
    end

    // fold into [-90, 90] degrees, seed the rotation
    always_comb
    begin
        logic signed [17:0]    a;
        logic signed [Z_W-1:0] z;
        a      = 18'(w_reg.angle);
        f_next = '0;
        f_next.geom = w_reg.geom;
        if (a > QUARTER_TURN)
        begin
            a = a - HALF_TURN;
            f_next.geom.neg = 1'b1;
        end
        else if (a < -QUARTER_TURN)
        begin
            a = a + HALF_TURN;
            f_next.geom.neg = 1'b1;
        end
        z        = Z_W'(a);
        f_next.x = CORDIC_GAIN_Q16;
        f_next.y = '0;
        f_next.z = {z[Z_W-9:0], 8'd0};
    end

    prc_cordic #(
        .STAGES(STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid_reg),
        .in_ready  (c_in_ready),
        .in_data   (f_reg),
        .out_valid (c_out_valid),
        .out_ready (g_rdy),
        .out_data  (c_out_data)
    );

    always_comb
    begin
        g_next.c  = c_out_data.geom.neg ? -c_out_data.x : c_out_data.x;
        g_next.s  = c_out_data.geom.neg ? -c_out_data.y : c_out_data.y;
        g_next.dx = c_out_data.geom.dx;
        g_next.dy = c_out_data.geom.dy;
        g_next.cx = c_out_data.geom.cx;
        g_next.y2 = $signed({1'b0, rows_reg}) - $signed({2'b00, c_out_data.geom.cy});
    end

    always_comb
    begin
        m_next.dxc = P_W'(g_reg.dx) * P_W'(g_reg.c);
        m_next.dys = P_W'(g_reg.dy) * P_W'(g_reg.s);
        m_next.dxs = P_W'(g_reg.dx) * P_W'(g_reg.s);
        m_next.dyc = P_W'(g_reg.dy) * P_W'(g_reg.c);
        m_next.cx  = g_reg.cx;
        m_next.y2  = g_reg.y2;
    end

    always_comb
    begin
        s_next.sx = SUM_W'(m_reg.dxc) - SUM_W'(m_reg.dys)
                  + $signed({5'd0, m_reg.cx, 16'd0});
        s_next.sy = SUM_W'(m_reg.dxs) + SUM_W'(m_reg.dyc)
                  + $signed({{3{m_reg.y2[13]}}, m_reg.y2, 16'd0});
    end

    always_comb
    begin
        r_next.qx = round_even(s_reg.sx);
        r_next.qy = round_even(s_reg.sy);
    end

    // flip y back, clamp to the output range
    always_comb
    begin
        ox_next = saturate(R_W'(r_reg.qx));
        oy_next = saturate($signed({5'd0, rows_reg}) - R_W'(r_reg.qy));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg    <= ROWS_W'(1024);
            w_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                rows_reg <= cfg_data;
            end
            if (w_rdy)
            begin
                w_valid_reg <= points.valid;
            end
            if (f_rdy)
            begin
                f_valid_reg <= w_valid_reg;
            end
            if (g_rdy)
            begin
                g_valid_reg <= c_out_valid;
            end
            if (m_rdy)
            begin
                m_valid_reg <= g_valid_reg;
            end
            if (s_rdy)
            begin
                s_valid_reg <= m_valid_reg;
            end
            if (r_rdy)
            begin
                r_valid_reg <= s_valid_reg;
            end
            if (o_rdy)
            begin
                o_valid_reg <= r_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (points.valid && w_rdy)
        begin
            w_reg <= w_next;
        end
        if (w_valid_reg && f_rdy)
        begin
            f_reg <= f_next;
        end
        if (c_out_valid && g_rdy)
        begin
            g_reg <= g_next;
        end
        if (g_valid_reg && m_rdy)
        begin
            m_reg <= m_next;
        end
        if (m_valid_reg && s_rdy)
        begin
            s_reg <= s_next;
        end
        if (s_valid_reg && r_rdy)
        begin
            r_reg <= r_next;
        end
        if (r_valid_reg && o_rdy)
        begin
            ox_reg <= ox_next;
            oy_reg <= oy_next;
        end
    end

endmodule

`default_nettype wire
